// ===== hdl/olte_pkg.sv =====
// shared constants, command codes and cell control type for the ordered list table engine
package olte_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 3;
    localparam int IN_IDX_W   = 8;
    localparam int FIDX_W     = 9;
    localparam int CNT_OUT_W  = 9;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd4;

    localparam logic signed [FIDX_W-1:0] FIDX_NONE = '1;

    typedef struct packed {
        logic              add;
        logic              cmp;
        logic [DATA_W-1:0] operand;
    } cell_ctrl_t;

endpackage

// ===== hdl/olte_if.sv =====
// request and response channel interfaces
interface olte_req_if;
    import olte_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [DATA_W-1:0]   value;
    logic [IN_IDX_W-1:0]        index;

    modport source (output valid, output func, output value, output index, input ready);
    modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface olte_rsp_if;
    import olte_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic signed [FIDX_W-1:0]   found_index;
    logic signed [DATA_W-1:0]   data;
    logic [CNT_OUT_W-1:0]       count;

    modport source (output valid, output ok, output found_index, output data, output count,
                    input ready);
    modport sink   (input valid, input ok, input found_index, input data, input count,
                    output ready);
endinterface

// ===== hdl/olte_cell.sv =====
// one list cell: holds an entry, compares it to the key, adds, loads or takes its neighbor
module olte_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  olte_pkg::cell_ctrl_t        ctrl,
    input  logic                        valid,
    input  logic                        wr_en,
    input  logic                        shift_en,
    input  logic [olte_pkg::DATA_W-1:0] neighbor,
    output logic [olte_pkg::DATA_W-1:0] entry,
    output logic                        match
);
    import olte_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              match_reg;
    logic              match_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (wr_en)
        begin
            entry_next = ctrl.operand;
        end
        else if (shift_en)
        begin
            entry_next = neighbor;
        end
        else if (ctrl.add && valid)
        begin
            entry_next = entry_reg + ctrl.operand;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp)
        begin
            match_next = valid && (entry_reg == ctrl.operand);
        end
    end

    // entry storage is undefined until written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ===== hdl/ordered_list_table_engine.sv =====
// ordered list table engine: a chain of entry cells with a small command sequencer
// push, add, get and unused codes go from idle to eval, where the response register is loaded
// find and remove pass eval, scan and done: compare in every cell, isolate the first match, resolve
// one request in flight: a new one is taken only while the sequencer is idle
// a finished response waits in its register while the next request enters; a stall holds the last step
// reset clears the count, sequencer and response valid; cell entries are undefined until written
module ordered_list_table_engine (
    input  logic             clk,
    input  logic             rst_n,
    olte_req_if.sink         req,
    olte_rsp_if.source       rsp
);
    import olte_pkg::*;

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;

    // latched request
    logic [FUNC_W-1:0]         func_reg;
    logic [DATA_W-1:0]         value_reg;
    logic [IN_IDX_W-1:0]       index_reg;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    // first-match resolution registers
    logic [CAPACITY-1:0]       lowbit_reg;
    logic [CAPACITY-1:0]       shift_mask_reg;
    logic                      any_reg;

    // response register
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic                      rsp_ok_reg;
    logic                      rsp_ok_next;
    logic signed [FIDX_W-1:0]  rsp_fidx_reg;
    logic signed [FIDX_W-1:0]  rsp_fidx_next;
    logic [DATA_W-1:0]         rsp_data_reg;
    logic [DATA_W-1:0]         rsp_data_next;
    logic [CNT_OUT_W-1:0]      rsp_count_reg;

    // cell chain
    cell_ctrl_t                ctrl;
    logic [DATA_W-1:0]         entries [CAPACITY];
    logic [CAPACITY-1:0]       match_vec;
    logic [CAPACITY-1:0]       cell_valid;
    logic [CAPACITY-1:0]       cell_wr;
    logic [CAPACITY-1:0]       cell_shift;

    logic                      accept;
    logic                      out_free;
    logic                      is_search;
    logic                      fin_go;
    logic                      full;
    logic                      get_ok;
    logic [DATA_W-1:0]         get_data;
    logic [IDX_W-1:0]          match_pos;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign is_search = (func_reg == FUNC_FIND) || (func_reg == FUNC_REMOVE);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign get_ok    = CMP_W'(index_reg) < CMP_W'(count_reg);

    // the request completes in eval for simple commands and in done for searches;
    // side effects land only on the cycle the response register is loaded
    assign fin_go = out_free &&
                    (((state_reg == ST_EVAL) && !is_search) || (state_reg == ST_DONE));

    assign ctrl.cmp     = (state_reg == ST_EVAL);
    assign ctrl.add     = fin_go && (state_reg == ST_EVAL) && (func_reg == FUNC_ADD);
    assign ctrl.operand = value_reg;

    // per-cell enables from the count and the shift mask
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_valid[i] = CNT_W'(i) < count_reg;
            cell_wr[i]    = fin_go && (state_reg == ST_EVAL) && (func_reg == FUNC_PUSH) &&
                            !full && (count_reg == CNT_W'(i));
            cell_shift[i] = fin_go && (state_reg == ST_DONE) && (func_reg == FUNC_REMOVE) &&
                            any_reg && shift_mask_reg[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : gen_cell
            // each cell at or above the first match takes its upper neighbor on a remove; the last one keeps itself
            olte_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .valid    (cell_valid[g]),
                .wr_en    (cell_wr[g]),
                .shift_en (cell_shift[g]),
                .neighbor (entries[(g + 1 < CAPACITY) ? g + 1 : g]),
                .entry    (entries[g]),
                .match    (match_vec[g])
            );
        end
    endgenerate

    // get read: the addressed cell drives an or tree
    always_comb
    begin
        get_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CMP_W'(index_reg) == CMP_W'(i))
            begin
                get_data = get_data | entries[i];
            end
        end
    end

    // position of the isolated lowest match
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (lowbit_reg[i])
            begin
                match_pos = match_pos | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (is_search)
                begin
                    state_next = ST_SCAN;
                end
                else if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response contents and count update
    always_comb
    begin
        count_next    = count_reg;
        rsp_ok_next   = 1'b0;
        rsp_fidx_next = FIDX_NONE;
        rsp_data_next = '0;
        case (func_reg)
            FUNC_PUSH:
            begin
                rsp_ok_next = !full;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FUNC_ADD:
            begin
                rsp_ok_next = 1'b1;
            end
            FUNC_GET:
            begin
                rsp_ok_next = get_ok;
                if (get_ok)
                begin
                    rsp_data_next = get_data;
                end
            end
            FUNC_FIND:
            begin
                rsp_ok_next = any_reg;
                if (any_reg)
                begin
                    rsp_fidx_next = FIDX_W'(match_pos);
                end
            end
            FUNC_REMOVE:
            begin
                rsp_ok_next = any_reg;
                if (any_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                rsp_ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fin_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fin_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= req.func;
            value_reg <= req.value;
            index_reg <= req.index;
        end
        // isolate the lowest match and mark every cell at or above it for the shift
        if (state_reg == ST_SCAN)
        begin
            lowbit_reg     <= match_vec & (~match_vec + CAPACITY'(1));
            shift_mask_reg <= ~((match_vec ^ (match_vec - CAPACITY'(1))) & ~match_vec);
            any_reg        <= |match_vec;
        end
        if (fin_go)
        begin
            rsp_ok_reg    <= rsp_ok_next;
            rsp_fidx_reg  <= rsp_fidx_next;
            rsp_data_reg  <= rsp_data_next;
            rsp_count_reg <= CNT_OUT_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.found_index = rsp_fidx_reg;
    assign rsp.data        = rsp_data_reg;
    assign rsp.count       = rsp_count_reg;

`ifndef NO_ASSERTIONS
    // the count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    // a successful remove shrinks the list by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && (state_reg == ST_DONE) && (func_reg == FUNC_REMOVE) && any_reg)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not shrink the list");

    // the scan step always moves on to resolution
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg == ST_DONE))
        else $error("scan step did not advance");

    // a new response is loaded only when the old one is gone or taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> ($stable(rsp_data_reg) && $stable(rsp_count_reg)))
        else $error("pending response overwritten");
`endif

endmodule
